// ===== rtl/serial_response_timeout_collector_unit_defines.svh =====
// ----------------------------------------------------------------------------
// serial response timeout collector: assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef SERIAL_RESPONSE_TIMEOUT_COLLECTOR_UNIT_DEFINES_SVH
`define SERIAL_RESPONSE_TIMEOUT_COLLECTOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define SRTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srtc same-cycle check failed");
// antecedent implies consequent in the next cycle
`define SRTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtc next-cycle check failed");
`else
`define SRTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SRTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/srtc_pkg.sv =====
// ----------------------------------------------------------------------------
// srtc_pkg
// shared types and codes of the serial response timeout collector
// ----------------------------------------------------------------------------
package srtc_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FIRST_WAIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_GAP   = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_FINISH = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [1:0] opcode;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic       overflow_flag;
    logic [8:0] response_length;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
  } result_t;

endpackage

// ===== rtl/srtc_in_stage.sv =====
// ----------------------------------------------------------------------------
// srtc_in_stage
// input register; holds one transaction until the core takes it
// ----------------------------------------------------------------------------
module srtc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  srtc_pkg::item_t in_item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output srtc_pkg::item_t item_o
);
  import srtc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/srtc_core.sv =====
// ----------------------------------------------------------------------------
// srtc_core
// phase control, timeout counters, byte count and result formation
// ----------------------------------------------------------------------------
module srtc_core #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srtc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [srtc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          fire_i,
  input  srtc_pkg::item_t               item_i,
  output logic                          res_valid_o,
  output srtc_pkg::result_t             res_o
);
  import srtc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

  function automatic logic [CfgW-1:0] at_least_one(input logic [CfgW-1:0] v);
    return (v == '0) ? CfgW'(1) : v;
  endfunction

  logic [CfgW-1:0] first_wait_q, idle_gap_q;
  phase_e          phase_q, phase_d;
  logic [CfgW-1:0] wait_left_q, wait_left_d, wait_dec;
  logic [CfgW-1:0] gap_left_q, gap_left_d, gap_dec;
  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic            ovf_q, ovf_d;

  assign wait_dec = wait_left_q - CfgW'(wait_left_q != '0);
  assign gap_dec  = gap_left_q - CfgW'(gap_left_q != '0);

  always_comb begin
    phase_d      = phase_q;
    wait_left_d  = wait_left_q;
    gap_left_d   = gap_left_q;
    byte_count_d = byte_count_q;
    ovf_d        = ovf_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (fire_i) begin
      case (item_i.opcode)
        OP_START: begin
          phase_d      = PH_WAIT;
          wait_left_d  = at_least_one(first_wait_q);
          gap_left_d   = '0;
          byte_count_d = '0;
          ovf_d        = 1'b0;
        end
        OP_BYTE: begin
          if (phase_q != PH_IDLE) begin
            phase_d    = PH_COLLECT;
            gap_left_d = at_least_one(idle_gap_q);
            if (byte_count_q < MaxCnt) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_BYTE;
              res_o.data_byte   = item_i.rx_byte;
              res_o.byte_index  = 8'(byte_count_q);
              byte_count_d      = byte_count_q + CntW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (phase_q == PH_WAIT) begin
            wait_left_d = wait_dec;
            if (wait_dec == '0) begin
              phase_d    = PH_COLLECT;
              gap_left_d = at_least_one(idle_gap_q);
            end
          end else if (phase_q == PH_COLLECT) begin
            gap_left_d = gap_dec;
            if (gap_dec == '0) begin
              phase_d               = PH_IDLE;
              res_valid_o           = 1'b1;
              res_o.result_kind     = KIND_FINISH;
              res_o.response_length = 9'(byte_count_q);
              res_o.overflow_flag   = ovf_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_wait_q <= CfgW'(100);
      idle_gap_q   <= CfgW'(10);
      phase_q      <= PH_IDLE;
      wait_left_q  <= '0;
      gap_left_q   <= '0;
      byte_count_q <= '0;
      ovf_q        <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_FIRST_WAIT) begin
        first_wait_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_IDLE_GAP) begin
        idle_gap_q <= cfg_wdata_i;
      end
      phase_q      <= phase_d;
      wait_left_q  <= wait_left_d;
      gap_left_q   <= gap_left_d;
      byte_count_q <= byte_count_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

// ===== rtl/srtc_out_stage.sv =====
// ----------------------------------------------------------------------------
// srtc_out_stage
// result register; holds a result until the sink takes the transaction
// ----------------------------------------------------------------------------
module srtc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              res_valid_i,
  input  srtc_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              advance_o,
  output srtc_pkg::result_t res_o
);
  import srtc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = fire_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/serial_response_timeout_collector_unit.sv =====
// ----------------------------------------------------------------------------
// serial_response_timeout_collector_unit
// collects one serial response framed by first-byte and idle-gap timeouts
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: opcode, rx_byte
// m_axis    out  m_axis_tvalid/tready       tdata: byte, index, length, ovf
//                                           tuser: result_kind
// cfg       in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle while the result is not stalled by m_axis_tready
// a result passes the input register and then the result register
// no clearing pass after reset; config regs reset to 100 and 10 ticks
// a stalled result holds the core, the input register takes one more
// ----------------------------------------------------------------------------
`include "serial_response_timeout_collector_unit_defines.svh"

module serial_response_timeout_collector_unit #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // opcode[1:0], rx_byte[9:2]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // data_byte[7:0], byte_index[15:8], response_length[24:16], overflow_flag[25]
  output logic [31:0]                  m_axis_tdata,
  output logic                         m_axis_tuser,   // result_kind[0]
  input  logic                         cfg_we_i,
  input  logic [srtc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [srtc_pkg::CfgW-1:0]    cfg_wdata_i
);
  import srtc_pkg::*;

  item_t   in_item, stage_item;
  logic    stage_valid;
  logic    advance;
  logic    fire;
  logic    res_valid;
  result_t core_res, out_res;

  assign in_item.opcode  = s_axis_tdata[1:0];
  assign in_item.rx_byte = s_axis_tdata[9:2];
  assign fire            = stage_valid && advance;

  srtc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  srtc_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (core_res)
  );

  srtc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (core_res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .advance_o   (advance),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.overflow_flag, out_res.response_length,
                         out_res.byte_index, out_res.data_byte};
  assign m_axis_tuser = out_res.result_kind;

  `SRTC_ASSERT_SAME(a_ready_low_means_full, clk_i, rst_ni, !s_axis_tready, stage_valid)
  `SRTC_ASSERT_SAME(a_fire_needs_room, clk_i, rst_ni, fire, !m_axis_tvalid || m_axis_tready)
  `SRTC_ASSERT_NEXT(a_result_reaches_out, clk_i, rst_ni, fire && res_valid, m_axis_tvalid)
  `SRTC_ASSERT_NEXT(a_stalled_item_kept, clk_i, rst_ni, stage_valid && !advance, stage_valid)

endmodule
